// ----- rtl/core/gbpf_pkg.sv -----
// ============================================================================
// Goldbach prime pair finder package
// Widths, field positions and the microcode program of the pair search.
// ============================================================================
package gbpf_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int SMALL_W     = 15;
    localparam int LARGE_W     = 16;
    localparam int OUT_FIELD_W = 1 + 1 + SMALL_W + LARGE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int VALID_BIT   = 0;
    localparam int FOUND_BIT   = 1;
    localparam int SMALL_LSB   = 2;
    localparam int LARGE_LSB   = SMALL_LSB + SMALL_W;
    localparam int SQ_W        = 2 * VALUE_BITS;
    localparam int CNT_W       = $clog2(VALUE_BITS);
    localparam int UPC_W       = 4;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_LOADV_P,
        OP_SQ,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_INC_D,
        OP_LOADV_Q,
        OP_INC_P,
        OP_SET_FOUND,
        OP_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_NOT_EVEN_GT2,
        C_P_GT_HALF,
        C_V_LT2,
        C_SQ_GT_V,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_SEL_SET,
        C_OUT_BUSY
    } ucond_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    localparam upc_t UA_WAIT   = 4'd0;
    localparam upc_t UA_INIT   = 4'd1;
    localparam upc_t UA_CAND   = 4'd2;
    localparam upc_t UA_TEST   = 4'd3;
    localparam upc_t UA_SQ     = 4'd4;
    localparam upc_t UA_DIVS   = 4'd5;
    localparam upc_t UA_DIV    = 4'd6;
    localparam upc_t UA_INCD   = 4'd7;
    localparam upc_t UA_LOOPD  = 4'd8;
    localparam upc_t UA_PRIME  = 4'd9;
    localparam upc_t UA_RETEST = 4'd10;
    localparam upc_t UA_NOTP   = 4'd11;
    localparam upc_t UA_FOUND  = 4'd12;
    localparam upc_t UA_EMIT   = 4'd13;
    localparam upc_t UA_RET    = 4'd14;

    // A taken condition jumps to target; otherwise the step counter advances.
    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        unique case (addr)
            UA_WAIT:   w = '{OP_LOAD,      C_NO_IN,        UA_WAIT};
            UA_INIT:   w = '{OP_INIT,      C_NOT_EVEN_GT2, UA_EMIT};
            UA_CAND:   w = '{OP_LOADV_P,   C_P_GT_HALF,    UA_EMIT};
            UA_TEST:   w = '{OP_NONE,      C_V_LT2,        UA_NOTP};
            UA_SQ:     w = '{OP_SQ,        C_NEVER,        UA_WAIT};
            UA_DIVS:   w = '{OP_DIV_START, C_SQ_GT_V,      UA_PRIME};
            UA_DIV:    w = '{OP_DIV_STEP,  C_DIV_BUSY,     UA_DIV};
            UA_INCD:   w = '{OP_INC_D,     C_REM_ZERO,     UA_NOTP};
            UA_LOOPD:  w = '{OP_NONE,      C_ALWAYS,       UA_SQ};
            UA_PRIME:  w = '{OP_LOADV_Q,   C_SEL_SET,      UA_FOUND};
            UA_RETEST: w = '{OP_NONE,      C_ALWAYS,       UA_TEST};
            UA_NOTP:   w = '{OP_INC_P,     C_ALWAYS,       UA_CAND};
            UA_FOUND:  w = '{OP_SET_FOUND, C_NEVER,        UA_WAIT};
            UA_EMIT:   w = '{OP_EMIT,      C_OUT_BUSY,     UA_EMIT};
            UA_RET:    w = '{OP_NONE,      C_ALWAYS,       UA_WAIT};
            default:   w = '{OP_NONE,      C_ALWAYS,       UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/goldbach_prime_pair_finder_unit.sv -----
// ============================================================================
// Goldbach prime pair finder unit
// Splits an even number into the pair of primes with the smallest lower
// member, using trial division driven by a microcoded sequencer.
// ============================================================================
//
//  Channel  Dir  Fields (tdata, lowest bit first)
//  s_axis   in   number[15:0]
//  m_axis   out  valid_res, found, small_prime[14:0], large_prime[15:0], pad
//
//  One item is in work at a time; s_axis_tready is high only at the wait step.
//  Each divisor trial runs through the bit-serial remainder unit, so the
//  work for an item grows with the divisors tried over all candidates and
//  their partners; odd inputs and inputs of 2 or less go straight to the emit step.
//  The result sits in an output register; a stalled m_axis holds the emit step.
//  Reset clears the step counter and the output valid flag.
module goldbach_prime_pair_finder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [gbpf_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // number
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // valid_res, found, small_prime, large_prime, zero pad
    output logic [gbpf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import gbpf_pkg::*;

    upc_t                     pc_reg, pc_next;
    uword_t                   uw;
    logic                     cond_hit;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic [VALUE_BITS-1:0]    n_reg, p_reg, v_reg, d_reg, dq_reg, rem_reg;
    logic [VALUE_BITS-1:0]    n_next, p_next, v_next, d_next, dq_next, rem_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     sel_reg, sel_next;
    logic                     valid_reg, valid_next;
    logic                     found_reg, found_next;

    logic [VALUE_BITS:0]      trial;
    logic [VALUE_BITS:0]      trial_diff;
    logic [VALUE_BITS-1:0]    partner;
    logic                     even_gt2;
    logic                     in_xfer;
    logic                     out_busy;

    assign uw            = ucode_rom(pc_reg);
    assign s_axis_tready = (pc_reg == UA_WAIT);
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_busy      = out_valid_reg & ~m_axis_tready;

    assign partner    = n_reg - p_reg;
    assign even_gt2   = ~n_reg[0] && (n_reg > VALUE_BITS'(2));
    assign trial      = {rem_reg, dq_reg[VALUE_BITS-1]};
    assign trial_diff = trial - {1'b0, d_reg};

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:        cond_hit = 1'b0;
            C_ALWAYS:       cond_hit = 1'b1;
            C_NO_IN:        cond_hit = ~s_axis_tvalid;
            C_NOT_EVEN_GT2: cond_hit = ~even_gt2;
            C_P_GT_HALF:    cond_hit = p_reg > (n_reg >> 1);
            C_V_LT2:        cond_hit = v_reg < VALUE_BITS'(2);
            C_SQ_GT_V:      cond_hit = sq_reg > SQ_W'(v_reg);
            C_DIV_BUSY:     cond_hit = cnt_reg != CNT_W'(VALUE_BITS - 1);
            C_REM_ZERO:     cond_hit = (rem_reg == '0);
            C_SEL_SET:      cond_hit = sel_reg;
            C_OUT_BUSY:     cond_hit = out_busy;
            default:        cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? uw.target : pc_reg + upc_t'(1);
    end

    always_comb
    begin
        n_next         = n_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        d_next         = d_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        valid_next     = valid_reg;
        found_next     = found_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        unique case (uw.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                if (in_xfer)
                begin
                    n_next = VALUE_BITS'(s_axis_tdata);
                end
            end
            OP_INIT:
            begin
                p_next     = VALUE_BITS'(1);
                valid_next = even_gt2;
                found_next = 1'b0;
            end
            OP_LOADV_P:
            begin
                v_next   = p_reg;
                d_next   = VALUE_BITS'(2);
                sel_next = 1'b0;
            end
            OP_SQ:
            begin
                sq_next = SQ_W'(d_reg) * SQ_W'(d_reg);
            end
            OP_DIV_START:
            begin
                rem_next = '0;
                dq_next  = v_reg;
                cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                if (!trial_diff[VALUE_BITS])
                begin
                    rem_next = trial_diff[VALUE_BITS-1:0];
                end
                else
                begin
                    rem_next = trial[VALUE_BITS-1:0];
                end
                dq_next  = dq_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_INC_D:
            begin
                d_next = d_reg + VALUE_BITS'(1);
            end
            OP_LOADV_Q:
            begin
                v_next   = partner;
                d_next   = VALUE_BITS'(2);
                sel_next = 1'b1;
            end
            OP_INC_P:
            begin
                p_next = p_reg + VALUE_BITS'(1);
            end
            OP_SET_FOUND:
            begin
                found_next = 1'b1;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[VALID_BIT] = valid_reg;
                    out_data_next[FOUND_BIT] = found_reg;
                    if (found_reg)
                    begin
                        out_data_next[SMALL_LSB +: SMALL_W] = SMALL_W'(p_reg);
                        out_data_next[LARGE_LSB +: LARGE_W] = LARGE_W'(partner);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= UA_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        p_reg        <= p_next;
        v_reg        <= v_next;
        d_reg        <= d_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        sq_reg       <= sq_next;
        cnt_reg      <= cnt_next;
        sel_reg      <= sel_next;
        valid_reg    <= valid_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/core/gbpf_checker.sv -----
// ============================================================================
// Goldbach prime pair finder checker
// Port-level checks on the input and result streams, bound to the top level.
// ============================================================================
module gbpf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // valid_res, found, small_prime, large_prime, zero pad
    input  logic [gbpf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import gbpf_pkg::*;

    logic in_xfer;

    assign in_xfer = s_axis_tvalid & s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed or dropped while stalled.");

    a_found_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[FOUND_BIT] |-> m_axis_tdata[VALID_BIT]
            && (m_axis_tdata[SMALL_LSB +: SMALL_W] != '0))
        else $error("Found pair without a valid even input.");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[FOUND_BIT] |->
            (m_axis_tdata[OUT_TDATA_W-1:SMALL_LSB] == '0))
        else $error("Primes reported without a found pair.");

    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("Second transfer accepted while an item is in work.");

endmodule

bind goldbach_prime_pair_finder_unit gbpf_checker u_gbpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
